// ===== design/sld_pkg.sv =====
// shared types and constants of the sync/length/crc-8 frame receiver
// no dependencies
`default_nettype none

package sld_pkg;

    typedef logic [7:0] t_byte;

    // control from the frame sequencer to the bit-serial crc unit
    typedef struct packed {
        logic start;   // absorb a new byte
        logic init;    // start from the initial value instead of the running crc
    } t_crc_ctl;

    localparam t_byte CRC_POLY = 8'h31;
    localparam t_byte CRC_INIT = 8'h00;
    localparam t_byte CRC_TOP  = 8'h80;

    // register select, paddr[2]
    localparam logic  REG_SYNC   = 1'b0;
    localparam t_byte SYNC_RESET = 8'hAA;

endpackage

`default_nettype wire

// ===== design/sync_len_crc8_deframer.sv =====
// top level of the sync/length/crc-8 frame receiver
// depends on sld_pkg, sld_ram, sld_crc8_ser
//
// Receives one byte per input transaction and extracts frames of the form
// sync, command, length, payload, crc. While hunting, a byte equal to the
// sync_byte register (APB offset 0x0, reset 0xAA) opens a frame; inside a
// frame every byte is data. A length above MAX_PAYLOAD drops back to hunting.
// The crc-8 (poly 0x31, init 0, msb first) covers command, length and payload
// and is computed bit-serially, one bit per cycle, so every command, in-range
// length and payload byte holds off the next byte until its crc steps are done;
// sync and hunting bytes do not wait on the crc, nor do a mismatching crc byte
// and an oversize length. On a matching crc byte the frame leaves as one
// output transaction per payload byte (read from the payload ram, one per
// cycle when the sink is ready, last flag on the final one), or as one
// transaction with zero payload when the length is zero; sink stalls hold
// the emission. A mismatch is dropped with no output. The result sits
// in an output register, so the receiver keeps taking bytes while the last
// result waits for the sink. No input is taken while a frame is being emitted.
`default_nettype none

module sync_len_crc8_deframer
    import sld_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // apb-style configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received bytes
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_rx_byte,
    // validated frame bytes
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_frame_cmd,
    output logic [5:0]  o_frame_len,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_byte_pos,
    output logic        o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0]    MAX_LEN_B = 8'(MAX_PAYLOAD);
    localparam logic [LW-1:0] LEN_ONE   = LW'(1);
    localparam logic [LW-1:0] LEN_ZERO  = '0;

    // frame phases
    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_PAY  = 3'd3;
    localparam logic [2:0] S_CRC  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // configuration register
    t_byte r_sync;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (cfg_wr && paddr[2] == REG_SYNC) begin
            r_sync <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_SYNC) begin
            prdata = {24'd0, r_sync};
        end
    end

    // frame sequencer state
    logic [2:0]    r_state, n_state;
    t_byte         r_cmd, n_cmd;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_rd_pos, n_rd_pos;

    // output register
    logic          r_out_valid, n_out_valid;
    t_byte         r_out_cmd, n_out_cmd;
    logic [5:0]    r_out_len, n_out_len;
    t_byte         r_out_byte, n_out_byte;
    logic [4:0]    r_out_pos, n_out_pos;
    logic          r_out_last, n_out_last;

    // crc unit and payload store
    t_crc_ctl      crc_ctl;
    t_byte         crc_val;
    logic          crc_busy;
    logic          ram_we;
    t_byte         ram_rdata;

    logic          in_fire;
    logic          out_free;
    logic          in_phase;
    logic [LW-1:0] fill_inc;
    logic [LW-1:0] pos_inc;
    logic [LW+4:0] pos_ext;
    logic [LW+5:0] len_ext;

    // every phase but emit takes bytes, never while the crc shifts
    assign in_phase   = (r_state != S_EMIT);
    assign o_in_ready = in_phase && !crc_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign fill_inc   = r_fill + LEN_ONE;
    assign pos_inc    = r_rd_pos + LEN_ONE;
    assign pos_ext    = {5'd0, r_rd_pos};
    assign len_ext    = {6'd0, r_len};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_fill      = r_fill;
        n_rd_pos    = r_rd_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_cmd   = r_out_cmd;
        n_out_len   = r_out_len;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        crc_ctl     = '{start: 1'b0, init: 1'b0};
        ram_we      = 1'b0;

        unique case (r_state)
            S_CMD: begin
                if (in_fire) begin
                    n_cmd   = i_rx_byte;
                    crc_ctl = '{start: 1'b1, init: 1'b1};
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (in_fire) begin
                    if (i_rx_byte > MAX_LEN_B) begin
                        n_state = S_HUNT;
                    end else begin
                        n_len   = i_rx_byte[LW-1:0];
                        n_fill  = LEN_ZERO;
                        crc_ctl = '{start: 1'b1, init: 1'b0};
                        n_state = (i_rx_byte == 8'd0) ? S_CRC : S_PAY;
                    end
                end
            end
            S_PAY: begin
                if (in_fire) begin
                    ram_we  = 1'b1;
                    n_fill  = fill_inc;
                    crc_ctl = '{start: 1'b1, init: 1'b0};
                    if (fill_inc >= r_len) begin
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (in_fire) begin
                    // store entry 0 is addressed here so its registered read data is ready when emission starts
                    n_rd_pos = LEN_ZERO;
                    n_state  = (i_rx_byte == crc_val) ? S_EMIT : S_HUNT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cmd   = r_cmd;
                    n_out_len   = len_ext[5:0];
                    if (r_len == LEN_ZERO) begin
                        n_out_byte = 8'd0;
                        n_out_pos  = 5'd0;
                        n_out_last = 1'b1;
                        n_state    = S_HUNT;
                    end else begin
                        n_out_byte = ram_rdata;
                        n_out_pos  = pos_ext[4:0];
                        n_out_last = (pos_inc == r_len);
                        n_rd_pos   = pos_inc;
                        if (pos_inc == r_len) begin
                            n_state = S_HUNT;
                        end
                    end
                end
            end
            default: begin
                // hunting, unknown codes hunt too
                if (in_fire) begin
                    n_state = (i_rx_byte == r_sync) ? S_CMD : S_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_out_valid <= 1'b0;
            r_len       <= LEN_ZERO;
            r_fill      <= LEN_ZERO;
            r_rd_pos    <= LEN_ZERO;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_rd_pos    <= n_rd_pos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_cmd  <= n_out_cmd;
        r_out_len  <= n_out_len;
        r_out_byte <= n_out_byte;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    sld_crc8_ser u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_rx_byte),
        .o_crc   (crc_val),
        .o_busy  (crc_busy)
    );

    // read address runs one step ahead so read data matches r_rd_pos
    sld_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (n_rd_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_frame_cmd    = r_out_cmd;
    assign o_frame_len    = r_out_len;
    assign o_payload_byte = r_out_byte;
    assign o_byte_pos     = r_out_pos;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ===== design/sld_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [AW-1:0]          i_waddr,
    input  wire [WIDTH-1:0]       i_wdata,
    input  wire [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/sld_crc8_ser.sv =====
// bit-serial crc-8 unit, one polynomial step per cycle
// depends on sld_pkg
`default_nettype none

module sld_crc8_ser
    import sld_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_crc_ctl i_ctl,
    input  wire t_byte    i_byte,
    output t_byte      o_crc,
    output logic       o_busy
);

    t_byte      r_crc, n_crc;
    logic [2:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;

    always_comb begin
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_ctl.start) begin
            n_crc  = (i_ctl.init ? CRC_INIT : r_crc) ^ i_byte;
            n_cnt  = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ((r_crc & CRC_TOP) != CRC_INIT) begin
                n_crc = {r_crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                n_crc = {r_crc[6:0], 1'b0};
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= 3'd0;
            r_busy <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== sim/sync_len_crc8_deframer_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for sync_len_crc8_deframer: random byte streams of framed data
// depends on sld_pkg and the deframer rtl; expected frames are predicted inside the bench

module sync_len_crc8_deframer_tb
    import sld_pkg::*;
();

    localparam int         MAX_LEN       = 32;
    localparam int         STALL_LIMIT   = 3000;  // cycles with no transaction at all
    localparam int         SETTLE_CYCLES = 24;    // crc steps of the last byte plus margin
    localparam int         DRAIN_CYCLES  = 40;

    // receive phases of the predictor
    typedef enum logic [2:0] {
        HUNT,
        GET_CMD,
        GET_LEN,
        GET_BODY,
        GET_CRC
    } t_rx_phase;

    // one output transaction of a validated frame
    typedef struct packed {
        t_byte      cmd;
        logic [5:0] len;
        t_byte      data;
        logic [4:0] pos;
        logic       last;
    } t_frame_beat;

    // predicts the frames that leave the block and checks them in order
    class t_frame_tracker;
        t_byte       sync_val;
        t_rx_phase   phase;
        t_byte       cmd_q;
        logic [5:0]  len_q;
        logic [5:0]  fill;
        t_byte       fcs;
        t_byte       body[MAX_LEN];
        t_frame_beat pending_beats[$];
        int          errors;
        int          beats_seen;
        int          frames_good;
        int          frames_bad;

        function new();
            sync_val    = SYNC_RESET;
            phase       = HUNT;
            cmd_q       = '0;
            len_q       = '0;
            fill        = '0;
            fcs         = CRC_INIT;
            errors      = 0;
            beats_seen  = 0;
            frames_good = 0;
            frames_bad  = 0;
        endfunction

        // crc-8, msb first, no reflection
        static function t_byte crc8_step(t_byte crc_in, t_byte b);
            t_byte c;
            c = crc_in ^ b;
            for (int k = 0; k < 8; k++)
                c = ((c & CRC_TOP) != 0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void absorb_byte(t_byte b);
            t_frame_beat beat;
            case (phase)
                GET_CMD: begin
                    cmd_q = b;
                    fcs   = crc8_step(CRC_INIT, b);
                    phase = GET_LEN;
                end
                GET_LEN: begin
                    if (b > MAX_LEN) begin
                        phase = HUNT;
                    end else begin
                        len_q = b[5:0];
                        fill  = '0;
                        fcs   = crc8_step(fcs, b);
                        phase = (b == 0) ? GET_CRC : GET_BODY;
                    end
                end
                GET_BODY: begin
                    body[fill] = b;
                    fill       = fill + 1'b1;
                    fcs        = crc8_step(fcs, b);
                    if (fill >= len_q)
                        phase = GET_CRC;
                end
                GET_CRC: begin
                    if (b == fcs) begin
                        frames_good++;
                        if (len_q == 0) begin
                            beat = '{cmd: cmd_q, len: '0, data: '0, pos: '0, last: 1'b1};
                            pending_beats.push_back(beat);
                        end else begin
                            for (int i = 0; i < len_q; i++) begin
                                beat.cmd  = cmd_q;
                                beat.len  = len_q;
                                beat.data = body[i];
                                beat.pos  = 5'(i);
                                beat.last = (i == len_q - 1);
                                pending_beats.push_back(beat);
                            end
                        end
                    end else begin
                        frames_bad++;
                    end
                    phase = HUNT;
                end
                default: phase = (b == sync_val) ? GET_CMD : HUNT;
            endcase
        endfunction

        function void check_beat(t_frame_beat got);
            t_frame_beat want;
            if (pending_beats.size() == 0) begin
                $error("unexpected result: frame_cmd %0h byte_pos %0d", got.cmd, got.pos);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            beats_seen++;
            if (got.cmd !== want.cmd) begin
                $error("frame_cmd: expected %0h, actual %0h", want.cmd, got.cmd);
                errors++;
            end
            if (got.len !== want.len) begin
                $error("frame_len: expected %0d, actual %0d", want.len, got.len);
                errors++;
            end
            if (got.data !== want.data) begin
                $error("payload_byte: expected %0h, actual %0h", want.data, got.data);
                errors++;
            end
            if (got.pos !== want.pos) begin
                $error("byte_pos: expected %0d, actual %0d", want.pos, got.pos);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and apb
    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    // byte input side
    logic        i_in_valid;
    wire         o_in_ready;
    logic [7:0]  i_rx_byte;

    // frame output side
    wire         o_out_valid;
    logic        i_out_ready;
    wire  [7:0]  o_frame_cmd;
    wire  [5:0]  o_frame_len;
    wire  [7:0]  o_payload_byte;
    wire  [4:0]  o_byte_pos;
    wire         o_last;

    t_frame_tracker frames;
    t_byte        frame_body[$];      // payload preset for the next frame, rest is random
    int           frame_bytes  = 0;   // bytes sent as part of frames, noise not counted
    int           quiet_cycles = 0;
    bit           idle_on      = 1'b1;

    sync_len_crc8_deframer #(
        .MAX_PAYLOAD(MAX_LEN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_cmd    (o_frame_cmd),
        .o_frame_len    (o_frame_len),
        .o_payload_byte (o_payload_byte),
        .o_byte_pos     (o_byte_pos),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // every result transaction is compared against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            frames.check_beat(t_frame_beat'{o_frame_cmd, o_frame_len, o_payload_byte,
                                            o_byte_pos, o_last});
    end

    // count cycles in which neither side moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // sink side: random stall bursts while idling is enabled, else always ready
    initial begin
        i_out_ready <= 1'b1;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // one byte transaction; valid stays up into the next byte unless a gap is drawn
    task automatic send_byte(input t_byte b);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        frames.absorb_byte(b);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // sync, command, length, then body and crc unless the length is out of range
    task automatic drive_frame(input t_byte cmd, input t_byte len_code, input bit corrupt);
        t_byte fcs;
        send_byte(frames.sync_val);
        send_byte(cmd);
        send_byte(len_code);
        frame_bytes += 3;
        if (len_code <= MAX_LEN) begin
            fcs = t_frame_tracker::crc8_step(t_frame_tracker::crc8_step(CRC_INIT, cmd),
                                             len_code);
            while (frame_body.size() < len_code)
                frame_body.push_back(8'($urandom_range(0, 255)));
            foreach (frame_body[i]) begin
                send_byte(frame_body[i]);
                fcs = t_frame_tracker::crc8_step(fcs, frame_body[i]);
            end
            if (corrupt)
                fcs ^= 8'($urandom_range(1, 255));
            send_byte(fcs);
            frame_bytes += len_code + 1;
        end
        frame_body.delete();
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // change the sync value only once all frames are out and the crc unit is done
    task automatic set_sync_when_idle(input t_byte value);
        i_in_valid <= 1'b0;
        while (frames.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write({REG_SYNC, 2'b00}, {24'h0, value});
        frames.sync_val = value;
    endtask

    // mostly good frames, some with bad crc, oversize lengths and hunting noise
    task automatic run_random_frames(input int budget);
        int stop_at;
        int pick;
        int len;
        stop_at = frame_bytes + budget;
        while (frame_bytes < stop_at) begin
            pick = $urandom_range(0, 19);
            // short payloads keep the run fast, a few reach the maximum
            len  = ($urandom_range(0, 11) == 0) ? $urandom_range(24, MAX_LEN)
                                                : $urandom_range(0, 6);
            if (pick < 14)
                drive_frame(8'($urandom_range(0, 255)), 8'(len), 1'b0);
            else if (pick < 16)
                drive_frame(8'($urandom_range(0, 255)), 8'(len), 1'b1);
            else if (pick == 16)
                drive_frame(8'($urandom_range(0, 255)), 8'($urandom_range(MAX_LEN + 1, 255)),
                            1'b0);
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        frames = new();
        // every input known from time zero
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset sync value
        // zero-length frame with an all-zero command
        drive_frame(8'h00, 8'd0, 1'b0);
        // single all-ones payload byte
        frame_body.push_back(8'hFF);
        drive_frame(8'hFF, 8'd1, 1'b0);
        // length one past the maximum goes straight back to hunting
        drive_frame(8'h12, 8'(MAX_LEN + 1), 1'b0);
        // sync value inside the body, crc wrong so the frame is dropped
        frame_body.push_back(8'hAA);
        frame_body.push_back(8'h00);
        drive_frame(8'h5A, 8'd2, 1'b1);
        // sync value inside the body, crc right
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hAA);
        drive_frame(8'h80, 8'd2, 1'b0);

        // random frames under several sync values, the extremes among them
        run_random_frames(25);
        set_sync_when_idle(8'h00);
        run_random_frames(25);
        set_sync_when_idle(8'hFF);
        run_random_frames(25);
        set_sync_when_idle(8'($urandom_range(1, 254)));

        // last part without idling, opened by a full-length frame
        idle_on = 1'b0;
        drive_frame(8'($urandom_range(0, 255)), 8'(MAX_LEN), 1'b0);
        run_random_frames(15);

        // drain what is still on its way out
        i_in_valid <= 1'b0;
        while (frames.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames.pending_beats.size() != 0) begin
            $error("%0d expected results never arrived", frames.pending_beats.size());
            frames.errors++;
        end

        $display("covered %0d frame bytes under four sync values", frame_bytes);
        $display("%0d frames passed crc, %0d dropped, %0d result transactions, %0d mismatches",
                 frames.frames_good, frames.frames_bad, frames.beats_seen, frames.errors);
        if (frames.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
